### rtl/psp_pkg.sv
// shared types and constants of the polygon support point block
`default_nettype none

package psp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W = 24;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int DIST_W  = 48;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int VERT_W  = 2 * COORD_W;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [APB_ADDR_W-1:0] REG_VERTEX_COUNT   = '0;
    localparam logic [COUNT_W-1:0]    VERTEX_COUNT_RESET = COUNT_W'(1);

    localparam logic signed [SUM_W-1:0] DIST_MAX_SUM =
        {{(SUM_W - DIST_W + 1){1'b0}}, {(DIST_W - 1){1'b1}}};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    typedef enum logic
    {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t             kind;
        logic [ADDR_W-1:0] index;
        logic [CNT_W-1:0]  count;
        coord_t            x;
        coord_t            y;
    } op_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } back_state_t;

    // number of vertices actually scanned for a programmed count
    function automatic logic [CNT_W-1:0] scan_count(input logic [COUNT_W-1:0] cfg);
        logic [CNT_W-1:0] n;
        if (cfg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (int'(cfg) > MAX_VERTICES)
        begin
            n = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n = CNT_W'(cfg);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/psp_if.sv
// item and result channel interfaces
`default_nettype none

interface psp_in_if import psp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [INDEX_W-1:0] vertex_index;
    coord_t             coord_x;
    coord_t             coord_y;

    modport source (output valid, output kind, output vertex_index, output coord_x,
                    output coord_y, input ready);
    modport sink (input valid, input kind, input vertex_index, input coord_x,
                  input coord_y, output ready);
endinterface

interface psp_out_if import psp_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t extreme_x;
    coord_t extreme_y;
    dist_t  extreme_distance;

    modport source (output valid, output extreme_x, output extreme_y,
                    output extreme_distance, input ready);
    modport sink (input valid, input extreme_x, input extreme_y,
                  input extreme_distance, output ready);
endinterface

`default_nettype wire

### rtl/psp_ram.sv
// generic single write port ram with registered read
`default_nettype none

module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/psp_front.sv
// item intake, classification and configuration register
`default_nettype none

module psp_front import psp_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    psp_in_if.sink                     item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output op_t                        push_op,
    output logic                       push_valid,
    input  wire logic                  push_ready
);

    logic [COUNT_W-1:0] vcount_reg;
    logic [COUNT_W-1:0] vcount_next;
    kind_t              kind;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_VERTEX_COUNT);

    always_comb
    begin
        vcount_next = vcount_reg;
        if (cfg_write)
        begin
            vcount_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VERTEX_COUNT_RESET;
        end
        else
        begin
            vcount_reg <= vcount_next;
        end
    end

    assign prdata = (paddr == REG_VERTEX_COUNT) ? APB_DATA_W'(vcount_reg) : '0;

    // loads outside the store are taken and dropped
    assign kind       = kind_t'(item.kind);
    assign item.ready = push_ready;
    assign push_valid = item.valid &&
                        ((kind == KIND_QUERY) || (int'(item.vertex_index) < MAX_VERTICES));

    assign push_op.kind  = kind;
    assign push_op.index = ADDR_W'(item.vertex_index);
    assign push_op.count = scan_count(vcount_reg);
    assign push_op.x     = item.coord_x;
    assign push_op.y     = item.coord_y;

endmodule

`default_nettype wire

### rtl/psp_queue.sv
// short operation queue between intake and scan engine
`default_nettype none

module psp_queue import psp_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire op_t  push_op,
    input  wire logic push_valid,
    output logic      push_ready,
    output op_t       pop_op,
    output logic      pop_valid,
    input  wire logic pop_ready
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;
    logic              push;
    logic              pop;

    assign push_ready = (fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

### rtl/psp_back.sv
// scan engine: vertex writes and support point search
`default_nettype none

module psp_back import psp_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire op_t               pop_op,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [VERT_W-1:0]      ram_wdata,
    output logic [ADDR_W-1:0]      ram_raddr,
    input  wire logic [VERT_W-1:0] ram_rdata,
    psp_out_if.source              result
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [CNT_W-1:0] iss_reg;
    logic [CNT_W-1:0] iss_next;
    logic             iss_active_reg;
    logic             iss_active_next;
    logic [CNT_W-1:0] count_reg;
    logic             start;

    logic rd_vld_reg, rd_vld_next;
    logic rd_first_reg, rd_first_next;
    logic rd_last_reg, rd_last_next;
    logic mul_vld_reg, mul_vld_next;
    logic mul_first_reg, mul_first_next;
    logic mul_last_reg, mul_last_next;
    logic out_valid_reg, out_valid_next;
    logic load_out;

    coord_t dir_x_reg;
    coord_t dir_y_reg;
    coord_t rd_x;
    coord_t rd_y;
    coord_t mvx_reg;
    coord_t mvy_reg;
    coord_t best_x_reg;
    coord_t best_y_reg;
    coord_t out_x_reg;
    coord_t out_y_reg;
    dist_t  out_d_reg;

    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] py_next;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  best_d_reg;
    logic                     take_best;

    assign pop_ready = (state_reg == S_IDLE);
    assign start     = pop_valid && pop_ready && (pop_op.kind == KIND_QUERY);

    assign ram_we    = pop_valid && pop_ready && (pop_op.kind == KIND_LOAD);
    assign ram_waddr = pop_op.index;
    assign ram_wdata = {pop_op.x, pop_op.y};
    assign ram_raddr = iss_reg[ADDR_W-1:0];

    assign rd_x    = coord_t'(ram_rdata[VERT_W-1:COORD_W]);
    assign rd_y    = coord_t'(ram_rdata[COORD_W-1:0]);
    assign px_next = rd_x * dir_x_reg;
    assign py_next = rd_y * dir_y_reg;

    // strictly greater keeps the lowest index on ties
    assign sum       = SUM_W'(px_reg) + SUM_W'(py_reg);
    assign take_best = mul_vld_reg && (mul_first_reg || (sum > best_d_reg));

    assign load_out = (state_reg == S_FINISH) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        iss_next        = iss_reg;
        iss_active_next = iss_active_reg;
        rd_vld_next     = iss_active_reg;
        rd_first_next   = (iss_reg == '0);
        rd_last_next    = (iss_reg == count_reg - 1'b1);
        mul_vld_next    = rd_vld_reg;
        mul_first_next  = rd_first_reg;
        mul_last_next   = rd_last_reg;
        out_valid_next  = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (iss_active_reg)
        begin
            iss_next = iss_reg + 1'b1;
            if (rd_last_next)
            begin
                iss_active_next = 1'b0;
            end
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    iss_next        = '0;
                    iss_active_next = 1'b1;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (mul_vld_reg && mul_last_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iss_reg        <= '0;
            iss_active_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            mul_vld_reg    <= 1'b0;
            mul_first_reg  <= 1'b0;
            mul_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            iss_active_reg <= iss_active_next;
            rd_vld_reg     <= rd_vld_next;
            rd_first_reg   <= rd_first_next;
            rd_last_reg    <= rd_last_next;
            mul_vld_reg    <= mul_vld_next;
            mul_first_reg  <= mul_first_next;
            mul_last_reg   <= mul_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dir_x_reg <= pop_op.x;
            dir_y_reg <= pop_op.y;
            count_reg <= pop_op.count;
        end
        px_reg  <= px_next;
        py_reg  <= py_next;
        mvx_reg <= rd_x;
        mvy_reg <= rd_y;
        if (take_best)
        begin
            best_d_reg <= sum;
            best_x_reg <= mvx_reg;
            best_y_reg <= mvy_reg;
        end
        if (load_out)
        begin
            out_x_reg <= best_x_reg;
            out_y_reg <= best_y_reg;
            out_d_reg <= (best_d_reg > DIST_MAX_SUM) ? DIST_MAX_SUM[DIST_W-1:0]
                                                     : best_d_reg[DIST_W-1:0];
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.extreme_x        = out_x_reg;
    assign result.extreme_y        = out_y_reg;
    assign result.extreme_distance = out_d_reg;

endmodule

`default_nettype wire

### rtl/polygon_support_point.sv
// polygon support point top level
//
// item channel: kind selects a vertex load or a direction query. a load writes
// coord_x/coord_y into the vertex store at vertex_index and gives no result.
// a query returns on the result channel the stored vertex with the greatest
// dot product with (coord_x, coord_y), ties to the lowest index, plus that
// exact Q24.24 product saturated to 48 bits.
// the APB port holds vertex_count at address 0; 0 scans one vertex and values
// above the store depth scan the whole store.
// items pass through a two-entry queue to the scan engine, so the item channel
// keeps taking transfers while a scan runs, until the queue is full.
// a load is written into the store as it leaves the queue. a query of n vertices
// reads one vertex per cycle from the store ram; the engine takes the next item
// only once the query's result has entered the output register.
// a result waits in the output register while the receiver stalls; the engine
// then holds the next finished result until that register is free.
// reset empties the queue and output register and sets vertex_count to 1; the
// vertex store is not cleared and must be loaded before it is queried.
`default_nettype none

module polygon_support_point import psp_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    psp_in_if.sink                     item,
    psp_out_if.source                  result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    op_t               push_op;
    logic              push_valid;
    logic              push_ready;
    op_t               pop_op;
    logic              pop_valid;
    logic              pop_ready;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VERT_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VERT_W-1:0] ram_rdata;

    psp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push_op    (push_op),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    psp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (push_op),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_op     (pop_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    psp_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    psp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_op    (pop_op),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .result    (result)
    );

endmodule

`default_nettype wire

### rtl/psp_checker.sv
// port level checks of the polygon support point block
`default_nettype none

module psp_checker import psp_pkg::*; (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [COORD_W-1:0]    out_x,
    input wire logic [COORD_W-1:0]    out_y,
    input wire logic [DIST_W-1:0]     out_d,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [APB_DATA_W-1:0] pwdata,
    input wire logic [APB_DATA_W-1:0] prdata,
    input wire logic                  pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_d))
        else $error("result changed while stalled");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr == REG_VERTEX_COUNT)
        |=> (paddr != REG_VERTEX_COUNT) ||
            (prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0])))
        else $error("vertex_count readback differs from written value");

    a_cfg_reset: assert property (@(posedge clk)
        $rose(rst_n) && (paddr == REG_VERTEX_COUNT)
        |-> prdata == APB_DATA_W'(VERTEX_COUNT_RESET))
        else $error("vertex_count not at reset value after reset");

endmodule

bind polygon_support_point psp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.extreme_x),
    .out_y     (result.extreme_y),
    .out_d     (result.extreme_distance),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire
